>>> rtl/core/hsfd_pkg.sv
// ----------------------------------------------------------------------------
// hsfd_pkg
// Types, constants and the CRC-8 step shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // Input request: one frame byte
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    // Result request: one decoded measurement
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        temperature_raw;
        logic [15:0]        humidity_raw;
        logic [1:0]         status;
    } t_result;

    // Completed frame passed from front to back
    typedef struct packed {
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        logic        t_bad;
        logic        h_bad;
    } t_frame;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_BAD = 2'd1;
    localparam logic [1:0] ST_HUM_BAD  = 2'd2;

    localparam logic [14:0] T_SCALE  = 15'd17500;
    localparam logic [13:0] H_SCALE  = 14'd12500;
    localparam logic [14:0] T_OFFSET = 15'd4500;
    localparam logic [13:0] H_OFFSET = 14'd600;
    localparam logic [13:0] H_MAX    = 14'd10000;

    localparam logic REG_CRC_EN = 1'b0;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/hsfd_front.sv
// ----------------------------------------------------------------------------
// hsfd_front
// Tracks the byte position, runs the word CRCs and assembles raw words.
// ----------------------------------------------------------------------------
module hsfd_front import hsfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_frame   o_q_frame
);

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  r_pos;
    logic [7:0]  r_crc;
    logic [15:0] r_t_word;
    logic [15:0] r_h_word;
    logic        r_t_bad;

    logic        accept;
    logic [2:0]  pos;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_new;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_comb begin
        pos = (i_item.frame_start || r_pos > POS_H_CRC) ? POS_T_MSB : r_pos;
        crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : r_crc;
        crc_new  = crc8_byte(crc_seed, i_item.rx_byte);
    end

    assign o_q_push        = accept && (pos == POS_H_CRC);
    assign o_q_frame.t_raw = r_t_word;
    assign o_q_frame.h_raw = r_h_word;
    assign o_q_frame.t_bad = r_t_bad;
    assign o_q_frame.h_bad = (r_crc != i_item.rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_T_MSB;
            r_crc <= CRC_INIT;
        end else if (accept) begin
            r_pos <= (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
            unique case (pos)
                POS_T_MSB, POS_T_LSB, POS_H_MSB, POS_H_LSB: r_crc <= crc_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            unique case (pos)
                POS_T_MSB: r_t_word <= {i_item.rx_byte, 8'h00};
                POS_T_LSB: r_t_word[7:0] <= i_item.rx_byte;
                POS_T_CRC: r_t_bad <= (r_crc != i_item.rx_byte);
                POS_H_MSB: r_h_word <= {i_item.rx_byte, 8'h00};
                POS_H_LSB: r_h_word[7:0] <= i_item.rx_byte;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/hsfd_fifo.sv
// ----------------------------------------------------------------------------
// hsfd_fifo
// Short frame queue between the front and the conversion pipeline.
// ----------------------------------------------------------------------------
module hsfd_fifo import hsfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_frame o_data,
    output logic   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_frame        r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/core/hsfd_back.sv
// ----------------------------------------------------------------------------
// hsfd_back
// Three-stage conversion pipeline: scale, divide by 65535, offset and clamp.
// ----------------------------------------------------------------------------
module hsfd_back import hsfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_crc_en,
    input  logic    i_q_empty,
    input  t_frame  i_q_frame,
    output logic    o_q_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    logic        r_s1_v;
    logic [30:0] r_s1_tp;
    logic [29:0] r_s1_hp;
    logic [15:0] r_s1_traw;
    logic [15:0] r_s1_hraw;
    logic [1:0]  r_s1_status;

    logic        r_s2_v;
    logic [14:0] r_s2_qt;
    logic [13:0] r_s2_qh;
    logic [15:0] r_s2_traw;
    logic [15:0] r_s2_hraw;
    logic [1:0]  r_s2_status;

    logic        r_out_v;
    t_result     r_out;

    logic        out_rdy;
    logic        s2_rdy;
    logic        s1_rdy;
    logic [1:0]  n_status;
    logic [30:0] t_sum;
    logic [29:0] h_sum;
    logic [13:0] h_diff;
    logic [13:0] n_hum;

    assign out_rdy = !r_out_v || i_pop;
    assign s2_rdy  = !r_s2_v || out_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign o_q_pop = !i_q_empty && s1_rdy;
    assign o_empty = !r_out_v;
    assign o_result = r_out;

    always_comb begin
        n_status = ST_OK;
        if (i_crc_en) begin
            if (i_q_frame.t_bad) begin
                n_status = ST_TEMP_BAD;
            end else if (i_q_frame.h_bad) begin
                n_status = ST_HUM_BAD;
            end
        end
        // x / 65535 == (x + (x >> 16) + 1) >> 16 for the products seen here
        t_sum  = r_s1_tp + (r_s1_tp >> 16) + 31'd1;
        h_sum  = r_s1_hp + (r_s1_hp >> 16) + 30'd1;
        h_diff = r_s2_qh - H_OFFSET;
        if (r_s2_qh < H_OFFSET) begin
            n_hum = '0;
        end else if (h_diff > H_MAX) begin
            n_hum = H_MAX;
        end else begin
            n_hum = h_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_v <= o_q_pop;
            end
            if (s2_rdy) begin
                r_s2_v <= r_s1_v;
            end
            if (out_rdy) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_tp     <= 31'(i_q_frame.t_raw) * 31'(T_SCALE);
            r_s1_hp     <= 30'(i_q_frame.h_raw) * 30'(H_SCALE);
            r_s1_traw   <= i_q_frame.t_raw;
            r_s1_hraw   <= i_q_frame.h_raw;
            r_s1_status <= n_status;
        end
        if (s2_rdy && r_s1_v) begin
            r_s2_qt     <= t_sum[30:16];
            r_s2_qh     <= h_sum[29:16];
            r_s2_traw   <= r_s1_traw;
            r_s2_hraw   <= r_s1_hraw;
            r_s2_status <= r_s1_status;
        end
        if (out_rdy && r_s2_v) begin
            r_out.temperature_centi <= $signed(r_s2_qt - T_OFFSET);
            r_out.humidity_centi    <= n_hum;
            r_out.temperature_raw   <= r_s2_traw;
            r_out.humidity_raw      <= r_s2_hraw;
            r_out.status            <= r_s2_status;
        end
    end

endmodule

>>> rtl/core/humidity_sensor_frame_decoder_core.sv
// Throughput: one frame byte per cycle while full is low, one result per six bytes.
// A result passes, once its sixth byte is accepted, through the frame queue,
// the scale multiply, the divide by 65535 and the offset/clamp register.
// full rises only when the frame queue holds QUEUE_DEPTH frames.
// Reset (synchronous, i_rst_n low): position to first byte, queue and pipeline
// emptied, CRC checking enabled.
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core
// Decodes six-byte temperature/humidity frames with CRC-8 checks.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core import hsfd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic   r_crc_en;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_frame q_in;
    t_frame q_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CRC_EN) ? {31'd0, r_crc_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CRC_EN) begin
            r_crc_en <= pwdata[0];
        end
    end

    hsfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_frame (q_in)
    );

    hsfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    hsfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_crc_en  (r_crc_en),
        .i_q_empty (q_empty),
        .i_q_frame (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

>>> sim/humidity_sensor_frame_decoder_core_test.sv
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core_test
// Self-checking bench for the frame decoder. Pushes a short directed table of
// frame bytes and then random frames, noise and broken frames under both CRC
// settings. Every popped reading is compared field by field against a pinned
// table reading or a behavioral decoder tracking frame position, CRC, raw words.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core_test import hsfd_pkg::*; ();

    localparam logic [2:0] CRC_EN_ADDR  = {REG_CRC_EN, 2'b00};
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         BACKLOG_HOLD = 300;
    localparam int         PHASE_BYTES  = 312;
    localparam int         DIR_ROWS     = 26;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       pinned;
        t_result    reading;
    } t_dir_row;

    typedef struct packed {
        logic    on;
        t_result reading;
    } t_pin;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_in_item    i_item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // decoder state mirrored by the bench
    logic [2:0]  frame_pos = '0;
    logic [7:0]  crc_acc = CRC_INIT;
    logic [15:0] t_word = '0;
    logic [15:0] h_word = '0;
    logic        t_bad = 1'b0;
    logic        crc_en = 1'b1;

    t_result pending_readings[$];
    t_pin    pinned_readings[$];
    int      n_mismatch = 0;
    int      bytes_sent = 0;
    int      quiet = 0;
    bit      no_gaps = 1'b0;
    bit      backlog_req = 1'b0;
    bit      backlog_done = 1'b0;
    int      hold_left = 0;

    // Directed frames: zero words, full-scale words, both CRCs bad,
    // humidity CRC bad after an aborted frame.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b1, '{-15'sd4500, 14'd0, 16'h0000, 16'h0000, ST_OK}},
        // back to back, no frame_start
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hAC, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hAC, 1'b0, 1'b1, '{15'sd13000, 14'd10000, 16'hFFFF, 16'hFFFF, ST_OK}},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{15'sd13000, 14'd0, 16'hFFFF, 16'h0000, ST_TEMP_BAD}},
        // partial frame, then restart
        '{8'h12, 1'b1, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{-15'sd4500, 14'd10000, 16'h0000, 16'hFFFF, ST_HUM_BAD}}
    };

    humidity_sensor_frame_decoder_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_next(crc_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Advance the mirrored decoder by one byte; a reading comes out on byte six.
    task automatic decode_byte(input t_in_item it, output bit has_reading,
                               output t_result r);
        logic [2:0] pos;
        logic       h_bad;
        int         t_c;
        int         h_c;
        has_reading = 1'b0;
        r = '0;
        pos = (it.frame_start || frame_pos > 3'd5) ? 3'd0 : frame_pos;
        case (pos)
            3'd0: begin
                crc_acc = crc_next(CRC_INIT, it.rx_byte);
                t_word = {it.rx_byte, 8'h00};
            end
            3'd1: begin
                crc_acc = crc_next(crc_acc, it.rx_byte);
                t_word[7:0] = it.rx_byte;
            end
            3'd2: t_bad = (crc_acc != it.rx_byte);
            3'd3: begin
                crc_acc = crc_next(CRC_INIT, it.rx_byte);
                h_word = {it.rx_byte, 8'h00};
            end
            3'd4: begin
                crc_acc = crc_next(crc_acc, it.rx_byte);
                h_word[7:0] = it.rx_byte;
            end
            default: ;
        endcase
        if (pos != 3'd5) begin
            frame_pos = pos + 3'd1;
        end else begin
            h_bad = (crc_acc != it.rx_byte);
            frame_pos = 3'd0;
            t_c = -4500 + int'((32'd17500 * 32'(t_word)) / 32'd65535);
            h_c = -600 + int'((32'd12500 * 32'(h_word)) / 32'd65535);
            if (h_c < 0) h_c = 0;
            if (h_c > 10000) h_c = 10000;
            r.temperature_centi = 15'(t_c);
            r.humidity_centi = 14'(h_c);
            r.temperature_raw = t_word;
            r.humidity_raw = h_word;
            if (crc_en && t_bad) r.status = ST_TEMP_BAD;
            else if (crc_en && h_bad) r.status = ST_HUM_BAD;
            else r.status = ST_OK;
            has_reading = 1'b1;
        end
    endtask

    // Check popped readings, then log accepted bytes.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      has_reading;
        t_pin    pin;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_readings.size() == 0) begin
                    $error("reading popped with none pending");
                    n_mismatch++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_result.temperature_centi !== want.temperature_centi) begin
                        $error("temperature_centi: expected %0d, got %0d",
                               want.temperature_centi, o_result.temperature_centi);
                        n_mismatch++;
                    end
                    if (o_result.humidity_centi !== want.humidity_centi) begin
                        $error("humidity_centi: expected %0d, got %0d",
                               want.humidity_centi, o_result.humidity_centi);
                        n_mismatch++;
                    end
                    if (o_result.temperature_raw !== want.temperature_raw) begin
                        $error("temperature_raw: expected %h, got %h",
                               want.temperature_raw, o_result.temperature_raw);
                        n_mismatch++;
                    end
                    if (o_result.humidity_raw !== want.humidity_raw) begin
                        $error("humidity_raw: expected %h, got %h",
                               want.humidity_raw, o_result.humidity_raw);
                        n_mismatch++;
                    end
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_result.status);
                        n_mismatch++;
                    end
                end
            end
            if (push && !full) begin
                pin = (pinned_readings.size() != 0) ? pinned_readings.pop_front() : '0;
                decode_byte(i_item, has_reading, got);
                if (has_reading) pending_readings.push_back(pin.on ? pin.reading : got);
            end
        end
    end

    // Watchdog: cycles with no request moving on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
            quiet = 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet++;
        end
    end

    // Reading side: random stalls, one long hold-off to back the queue up
    initial begin
        forever begin
            @(posedge i_clk);
            if (backlog_req && !backlog_done && hold_left == 0) hold_left = BACKLOG_HOLD;
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
                if (hold_left == 0) backlog_done = 1'b1;
            end else if (no_gaps) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 10);
            end
        end
    end

    task automatic send_byte(input t_in_item it, input t_pin pin);
        while (!no_gaps && $urandom_range(99) < 10) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        pinned_readings.push_back(pin);
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == CRC_EN_ADDR) crc_en = data[0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Full-scale and clamp-edge words four times in ten, the rest uniform
    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(3140 + $urandom_range(12));
            3: return 16'(55568 + $urandom_range(12));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic fs);
        logic [15:0] tw;
        logic [15:0] hw;
        logic [7:0]  tc;
        logic [7:0]  hc;
        tw = pick_word();
        hw = pick_word();
        tc = word_crc(tw);
        hc = word_crc(hw);
        if ($urandom_range(99) < 15) tc ^= 8'($urandom_range(1, 255));
        if ($urandom_range(99) < 15) hc ^= 8'($urandom_range(1, 255));
        send_byte('{rx_byte: tw[15:8], frame_start: fs}, '0);
        send_byte('{rx_byte: tw[7:0], frame_start: 1'b0}, '0);
        send_byte('{rx_byte: tc, frame_start: 1'b0}, '0);
        send_byte('{rx_byte: hw[15:8], frame_start: 1'b0}, '0);
        send_byte('{rx_byte: hw[7:0], frame_start: 1'b0}, '0);
        send_byte('{rx_byte: hc, frame_start: 1'b0}, '0);
    endtask

    initial begin
        bit aligned;
        int phase_end;
        int pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte('{rx_byte: dir_rows[i].rx_byte, frame_start: dir_rows[i].frame_start},
                      '{on: dir_rows[i].pinned, reading: dir_rows[i].reading});
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CRC_EN_ADDR, (ph % 2 == 0) ? 32'd0 : 32'd1);
            no_gaps = (ph == 0);
            backlog_req = (ph == 1);
            aligned = 1'b1;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    // after noise the frame must restart explicitly
                    send_frame(aligned ? 1'($urandom_range(1)) : 1'b1);
                    aligned = 1'b1;
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 5)) begin
                        send_byte('{rx_byte: 8'($urandom), frame_start: 1'b0}, '0);
                    end
                    aligned = 1'b0;
                end else begin
                    send_byte('{rx_byte: 8'($urandom), frame_start: 1'($urandom_range(1))},
                              '0);
                    aligned = 1'b0;
                end
            end
            drain();
        end

        if (n_mismatch == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
